FILE: sv/ehr_pkg.sv
`default_nettype none
package ehr_pkg;

   localparam int CHANNELS_DEF = 8;

   localparam int VAL_W  = 15;
   localparam int SAMP_W = 16;
   localparam int PCT_W  = 14;
   localparam int PROD_W = VAL_W + PCT_W;

   localparam logic [3:0]       EMA_SHIFT_RST  = 4'd3;
   localparam logic [VAL_W-1:0] THRESHOLD_RST  = 15'd64;
   localparam logic [VAL_W-1:0] VREF_FLOOR_RST = 15'd16;
   localparam logic [PCT_W-1:0] PCT_SCALE      = 14'd10000;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_SHIFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VREF_FLOOR = 2'd2;

   typedef enum logic [1:0] {
      OP_SEED   = 2'd0,
      OP_SETTLE = 2'd1,
      OP_ARM    = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   // one channel entry of the state memory
   typedef struct packed {
      logic [VAL_W-1:0] reported;
      logic [VAL_W-1:0] raw;
      logic [VAL_W-1:0] filtered;
   } chan_state_type;

endpackage
`default_nettype wire

FILE: sv/ehr_chan_mem.sv
`default_nettype none
module ehr_chan_mem #(
   parameter int CHANNELS = ehr_pkg::CHANNELS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              rd_en,
   input  wire  [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
   output ehr_pkg::chan_state_type          rd_data,
   input  wire                              wr_en,
   input  wire  [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
   input  ehr_pkg::chan_state_type          wr_data
);

   ehr_pkg::chan_state_type store_ff [CHANNELS];
   logic [CHANNELS-1:0]     valid_ff;
   ehr_pkg::chan_state_type rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

FILE: sv/ehr_pct_div.sv
`default_nettype none
module ehr_pct_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [ehr_pkg::PROD_W-1:0]   dividend,
   input  wire  [ehr_pkg::VAL_W-1:0]    divisor,
   output logic                         done,
   output logic [ehr_pkg::PCT_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(ehr_pkg::PCT_W + 1);

   logic [ehr_pkg::VAL_W-1:0] rem_ff;
   logic [ehr_pkg::PCT_W-1:0] low_ff;
   logic [ehr_pkg::VAL_W-1:0] dvs_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;

   logic [ehr_pkg::VAL_W:0]   trial;
   logic                      fits;
   logic [ehr_pkg::VAL_W:0]   trial_sub;

   // restoring division, one quotient bit per cycle; dividend < divisor * 2^PCT_W
   assign trial     = {rem_ff, low_ff[ehr_pkg::PCT_W-1]};
   assign fits      = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ehr_pkg::PCT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[ehr_pkg::PROD_W-1:ehr_pkg::PCT_W];
         low_ff <= dividend[ehr_pkg::PCT_W-1:0];
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial_sub[ehr_pkg::VAL_W-1:0] : trial[ehr_pkg::VAL_W-1:0];
         low_ff <= {low_ff[ehr_pkg::PCT_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule
`default_nettype wire

FILE: sv/multichannel_ema_hysteresis_reporter_unit.sv
// Per-channel potentiometer filter with hysteresis reporting.
// req channel: one transfer per item. tuser carries op and channel, tdata the
// sample (negative values clamp to zero) and the reference reading. Each item
// reads its channel entry from a one-port-read, one-port-write state memory,
// applies seed, settle, arm or moving-average update, writes the entry back
// and gives one rsp transfer with filtered, raw, the report flag (tuser) and
// the percent of reference in hundredths.
// Each item passes through memory read, update, hysteresis and multiply,
// divider start, the restoring divider and output; when the percent is zero
// the divider steps are skipped. One item is in flight at a time: a new item
// is taken only in the idle state, which the block reaches once the current
// item has left the output state.
// The rsp output register decouples the sides: a new item is taken while a
// result still waits, and a stalled receiver holds the block only once the
// next result is ready. Reset clears the state memory (per-entry valid bits)
// and loads the csr registers with their defaults; no clearing pass is needed.
// csr writes are taken in any cycle; write them only while the block is idle.
`default_nettype none
module multichannel_ema_hysteresis_reporter_unit #(
   parameter int CHANNELS = ehr_pkg::CHANNELS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // req_tdata: sample [15:0], vref [30:16], zero [31]
   input  wire  [31:0] req_tdata,
   // req_tuser: op [1:0], channel [4:2]
   input  wire  [4:0]  req_tuser,
   input  wire         req_tvalid,
   output logic        req_tready,
   // rsp_tdata: filtered [14:0], raw_value [29:15], percent_hundredths [43:30], zero [47:44]
   output logic [47:0] rsp_tdata,
   // rsp_tuser: reported [0]
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [ehr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [ehr_pkg::VAL_W-1:0]     csr_data
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int VW = ehr_pkg::VAL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [3:0]    shift_ff;
   logic [VW-1:0] thresh_ff;
   logic [VW-1:0] floor_ff;

   ehr_pkg::op_type op_ff;
   logic [2:0]      chan_ff;
   logic            inrange_ff;
   logic [VW-1:0]   samp_ff;
   logic [VW-1:0]   vref_ff;
   logic [VW-1:0]   f_ff;
   logic [VW-1:0]   raw_ff;
   logic [VW-1:0]   last_ff;
   logic            rep_ff;
   logic [ehr_pkg::PROD_W-1:0] prod_ff;
   logic [ehr_pkg::PCT_W-1:0]  pct_ff;

   logic [VW-1:0]              rsp_f_ff;
   logic [VW-1:0]              rsp_raw_ff;
   logic [ehr_pkg::PCT_W-1:0]  rsp_pct_ff;
   logic                       rsp_rep_ff;
   logic                       rsp_valid_ff;

   ehr_pkg::chan_state_type cur;
   ehr_pkg::chan_state_type wr_data;
   logic                    mem_rd_en;
   logic                    mem_wr_en;
   logic [AW-1:0]           mem_addr;

   logic signed [VW:0]      ema_diff;
   logic signed [VW:0]      ema_step;
   logic signed [VW:0]      ema_sum;
   logic [VW:0]             avg_sum;
   logic [VW-1:0]           f_in;
   logic [VW-1:0]           raw_in;

   logic [VW-1:0]              last_diff;
   logic                       hit;
   logic [VW-1:0]              rep_in;
   logic [VW-1:0]              counts;
   logic [ehr_pkg::PROD_W-1:0] prod_in;
   logic                       pct_zero;

   logic                       div_done;
   logic [ehr_pkg::PCT_W-1:0]  div_quot;

   logic req_xfer;
   logic out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign mem_addr  = AW'(chan_ff);
   assign mem_rd_en = (state_ff == ST_READ);
   assign mem_wr_en = (state_ff == ST_MUL) && inrange_ff;

   ehr_chan_mem #(
      .CHANNELS (CHANNELS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (cur),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (wr_data)
   );

   ehr_pct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_START),
      .dividend (prod_ff),
      .divisor  (vref_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // channel update; arithmetic shift gives the rounded-down step for negative differences
   always_comb begin
      ema_diff = $signed({1'b0, samp_ff}) - $signed({1'b0, cur.filtered});
      ema_step = ema_diff >>> shift_ff;
      ema_sum  = $signed({1'b0, cur.filtered}) + ema_step;
      avg_sum  = {1'b0, cur.filtered} + {1'b0, samp_ff};
      case (op_ff)
         ehr_pkg::OP_SEED: begin
            f_in   = samp_ff;
            raw_in = samp_ff;
         end
         ehr_pkg::OP_SETTLE: begin
            f_in   = avg_sum[VW:1];
            raw_in = cur.raw;
         end
         ehr_pkg::OP_ARM: begin
            f_in   = cur.filtered;
            raw_in = cur.raw;
         end
         ehr_pkg::OP_UPDATE: begin
            f_in   = ema_sum[VW-1:0];
            raw_in = samp_ff;
         end
         default: begin
            f_in   = cur.filtered;
            raw_in = cur.raw;
         end
      endcase
   end

   // hysteresis and percent operand
   always_comb begin
      last_diff = (f_ff > last_ff) ? (f_ff - last_ff) : (last_ff - f_ff);
      hit       = (op_ff == ehr_pkg::OP_UPDATE) && (last_diff >= thresh_ff);
      if (hit || (op_ff == ehr_pkg::OP_ARM)) begin
         rep_in = f_ff;
      end else begin
         rep_in = last_ff;
      end
      counts   = (f_ff > vref_ff) ? vref_ff : f_ff;
      prod_in  = ehr_pkg::PROD_W'(counts) * ehr_pkg::PROD_W'(ehr_pkg::PCT_SCALE);
      pct_zero = !inrange_ff || (vref_ff < floor_ff) || (vref_ff == '0);
      wr_data.reported = rep_in;
      wr_data.raw      = raw_ff;
      wr_data.filtered = f_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= ehr_pkg::EMA_SHIFT_RST;
         thresh_ff    <= ehr_pkg::THRESHOLD_RST;
         floor_ff     <= ehr_pkg::VREF_FLOOR_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ehr_pkg::CSR_EMA_SHIFT:  shift_ff  <= csr_data[3:0];
               ehr_pkg::CSR_THRESHOLD:  thresh_ff <= csr_data;
               ehr_pkg::CSR_VREF_FLOOR: floor_ff  <= csr_data;
               default: ;
            endcase
         end

         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= pct_zero ? ST_OUT : ST_START;
            end
            ST_START: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // item payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff      <= ehr_pkg::op_type'(req_tuser[1:0]);
         chan_ff    <= req_tuser[4:2];
         inrange_ff <= 32'(req_tuser[4:2]) < 32'(CHANNELS);
         samp_ff    <= req_tdata[15] ? '0 : req_tdata[VW-1:0];
         vref_ff    <= req_tdata[30:16];
      end
      if (state_ff == ST_CALC) begin
         f_ff    <= f_in;
         raw_ff  <= raw_in;
         last_ff <= cur.reported;
      end
      if (state_ff == ST_MUL) begin
         rep_ff  <= hit;
         prod_ff <= prod_in;
         pct_ff  <= '0;
      end
      if ((state_ff == ST_DIV) && div_done) begin
         pct_ff <= div_quot;
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_f_ff   <= inrange_ff ? f_ff   : '0;
         rsp_raw_ff <= inrange_ff ? raw_ff : '0;
         rsp_rep_ff <= inrange_ff && rep_ff;
         rsp_pct_ff <= pct_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_pct_ff, rsp_raw_ff, rsp_f_ff};
   assign rsp_tuser  = rsp_rep_ff;

endmodule
`default_nettype wire

FILE: test/multichannel_ema_hysteresis_reporter_unit_tb.sv
`timescale 1ns / 1ps
module multichannel_ema_hysteresis_reporter_unit_tb;

   localparam int DRAIN_CYCLES     = 30;
   localparam int ITEMS_PER_PHASE  = 160;
   localparam int RANDOM_PHASES    = 9;
   localparam int CYCLE_LIMIT      = 1000000;

   typedef struct packed {
      logic [ehr_pkg::VAL_W-1:0] filtered;
      logic [ehr_pkg::VAL_W-1:0] raw;
      logic                      reported;
      logic [ehr_pkg::PCT_W-1:0] pct;
   } reading_type;

   typedef enum logic [1:0] {ROW_ITEM, ROW_FIXED, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      ehr_pkg::op_type               op;
      logic [2:0]                    ch;
      logic [15:0]                   sample;
      logic [ehr_pkg::VAL_W-1:0]     vref;
      reading_type                   want;
      logic [ehr_pkg::CSR_IDX_W-1:0] idx;
      logic [ehr_pkg::VAL_W-1:0]     value;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic [4:0]  req_tuser = '0;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   wire  [47:0] rsp_tdata;
   wire         rsp_tuser;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [ehr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ehr_pkg::VAL_W-1:0]     csr_data = '0;

   // predictor state and register copies
   logic [ehr_pkg::VAL_W-1:0] filt_mem [8];
   logic [ehr_pkg::VAL_W-1:0] raw_mem [8];
   logic [ehr_pkg::VAL_W-1:0] last_mem [8];
   logic [3:0]                shift_cfg = ehr_pkg::EMA_SHIFT_RST;
   logic [ehr_pkg::VAL_W-1:0] threshold_cfg = ehr_pkg::THRESHOLD_RST;
   logic [ehr_pkg::VAL_W-1:0] floor_cfg = ehr_pkg::VREF_FLOOR_RST;

   reading_type  pending_readings [$];
   plan_row_type plan [$];
   int        errors = 0;
   int        items_sent = 0;
   int        cycle_count = 0;
   int        stall_left = 0;
   bit        sender_idles = 1'b1;
   bit        receiver_stalls = 1'b1;

   multichannel_ema_hysteresis_reporter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clamp15(int v);
      if (v < 0) return 0;
      if (v > 32767) return 32767;
      return v;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic reading_type predict_reading(ehr_pkg::op_type op, logic [2:0] ch,
                                                   logic [15:0] sample,
                                                   logic [ehr_pkg::VAL_W-1:0] vref);
      int s;
      int f;
      int d;
      int diff;
      int c;
      reading_type r;
      s = sample[15] ? 0 : int'(sample);
      f = filt_mem[ch];
      r = '0;
      case (op)
         ehr_pkg::OP_SEED: begin
            raw_mem[ch] = ehr_pkg::VAL_W'(s);
            f = s;
         end
         ehr_pkg::OP_SETTLE: f = (f + s) >> 1;
         ehr_pkg::OP_ARM: last_mem[ch] = ehr_pkg::VAL_W'(f);
         ehr_pkg::OP_UPDATE: begin
            raw_mem[ch] = ehr_pkg::VAL_W'(s);
            d = s - f;
            f = (f + (d >>> shift_cfg)) & 32'h7FFF;
            diff = (f > int'(last_mem[ch])) ? f - int'(last_mem[ch])
                                              : int'(last_mem[ch]) - f;
            if (diff >= int'(threshold_cfg)) begin
               last_mem[ch] = ehr_pkg::VAL_W'(f);
               r.reported = 1'b1;
            end
         end
         default: ;
      endcase
      filt_mem[ch] = ehr_pkg::VAL_W'(f);
      r.filtered = ehr_pkg::VAL_W'(f);
      r.raw = raw_mem[ch];
      if (vref >= floor_cfg && vref != 0) begin
         c = (f > int'(vref)) ? int'(vref) : f;
         r.pct = ehr_pkg::PCT_W'((c * int'(ehr_pkg::PCT_SCALE)) / int'(vref));
      end
      return r;
   endfunction

   // entered right after a rising edge; leaves req_tvalid high after the transfer
   task automatic send_item(ehr_pkg::op_type op, logic [2:0] ch, logic [15:0] sample,
                            logic [ehr_pkg::VAL_W-1:0] vref, bit fixed, reading_type want);
      int gap;
      reading_type predicted;
      gap = (sender_idles && $urandom_range(0, 99) >= 60) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {1'b0, vref, sample};
      req_tuser <= {ch, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = predict_reading(op, ch, sample, vref);
      pending_readings.push_back(fixed ? want : predicted);
      items_sent++;
   endtask

   task automatic drain(int extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(logic [ehr_pkg::CSR_IDX_W-1:0] idx,
                            logic [ehr_pkg::VAL_W-1:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ehr_pkg::CSR_EMA_SHIFT:  shift_cfg = value[3:0];
         ehr_pkg::CSR_THRESHOLD:  threshold_cfg = value;
         ehr_pkg::CSR_VREF_FLOOR: floor_cfg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ehr_pkg::VAL_W-1:0] random_vref();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 18) return ehr_pkg::VAL_W'($urandom_range(0, 64));
      if (r < 26) return 15'h7FFF;
      if (r < 34) return ehr_pkg::VAL_W'(clamp15(int'(floor_cfg) + $urandom_range(0, 2) - 1));
      return ehr_pkg::VAL_W'($urandom_range(0, 32767));
   endfunction

   function automatic logic [15:0] random_sample(int level);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return {1'b1, 15'($urandom_range(0, 32767))};
      if (r < 14) return (r < 11) ? 16'd0 : 16'd32767;
      if (r < 24) return 16'($urandom_range(0, 32767));
      return 16'(clamp15(level + $urandom_range(0, 80) - 40));
   endfunction

   // seed, settle a few times, arm, then a run of updates drifting around
   task automatic run_sequence();
      logic [2:0] ch;
      int level;
      int settles;
      int updates;
      int spread;
      ch = 3'($urandom_range(0, 7));
      level = $urandom_range(0, 32767);
      spread = ($urandom_range(0, 3) == 0) ? 4000 : 150;
      settles = $urandom_range(0, 3);
      updates = $urandom_range(3, 15);
      send_item(ehr_pkg::OP_SEED, ch, random_sample(level), random_vref(), 1'b0, '0);
      repeat (settles) send_item(ehr_pkg::OP_SETTLE, ch, random_sample(level),
                                 random_vref(), 1'b0, '0);
      send_item(ehr_pkg::OP_ARM, ch, random_sample(level), random_vref(), 1'b0, '0);
      repeat (updates) begin
         level = clamp15(level + $urandom_range(0, 2 * spread) - spread);
         send_item(ehr_pkg::OP_UPDATE, ch, random_sample(level), random_vref(), 1'b0, '0);
      end
   endtask

   function automatic plan_row_type item_row(ehr_pkg::op_type op, logic [2:0] ch,
                                             logic [15:0] sample,
                                             logic [ehr_pkg::VAL_W-1:0] vref);
      plan_row_type row;
      row = '{ROW_ITEM, op, ch, sample, vref, '0, '0, '0};
      return row;
   endfunction

   function automatic plan_row_type fixed_row(ehr_pkg::op_type op, logic [2:0] ch,
                                              logic [15:0] sample,
                                              logic [ehr_pkg::VAL_W-1:0] vref,
                                              reading_type want);
      plan_row_type row;
      row = '{ROW_FIXED, op, ch, sample, vref, want, '0, '0};
      return row;
   endfunction

   function automatic plan_row_type csr_row(logic [ehr_pkg::CSR_IDX_W-1:0] idx,
                                            logic [ehr_pkg::VAL_W-1:0] value);
      plan_row_type row;
      row = '{ROW_CSR, ehr_pkg::OP_SEED, '0, '0, '0, '0, idx, value};
      return row;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(negedge clock) begin
      if (reset || !receiver_stalls) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 75) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left <= pick_gap() - 1;
         rsp_tready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[14:0], rsp_tdata[29:15], rsp_tuser, rsp_tdata[43:30]};
         if (pending_readings.size() == 0) begin
            $display("%0t: result transfer with nothing expected, actual %h", $time, got);
            errors++;
         end else begin
            want = pending_readings.pop_front();
            check_field("filtered", want.filtered, got.filtered);
            check_field("raw_value", want.raw, got.raw);
            check_field("reported", want.reported, got.reported);
            check_field("percent_hundredths", want.pct, got.pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  pending_readings.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      plan_row_type row;
      int phase;
      int phase_start;
      int r;
      for (int i = 0; i < 8; i++) begin
         filt_mem[i] = '0;
         raw_mem[i] = '0;
         last_mem[i] = '0;
      end

      // defaults after reset
      plan.push_back(fixed_row(ehr_pkg::OP_SETTLE, 3'd0, 16'd0, 15'd100, '{0, 0, 0, 0}));
      plan.push_back(fixed_row(ehr_pkg::OP_UPDATE, 3'd1, 16'd0, 15'd0, '{0, 0, 0, 0}));
      plan.push_back(fixed_row(ehr_pkg::OP_SEED, 3'd2, 16'd32767, 15'd32767,
                               '{32767, 32767, 0, 10000}));
      plan.push_back(fixed_row(ehr_pkg::OP_SEED, 3'd3, 16'h8000, 15'd1000, '{0, 0, 0, 0}));
      plan.push_back(fixed_row(ehr_pkg::OP_SEED, 3'd4, 16'hFFFF, 15'd15, '{0, 0, 0, 0}));
      plan.push_back(fixed_row(ehr_pkg::OP_SEED, 3'd5, 16'd1000, 15'd500,
                               '{1000, 1000, 0, 10000}));
      plan.push_back(item_row(ehr_pkg::OP_SETTLE, 3'd5, 16'd2000, 15'd32767));
      plan.push_back(item_row(ehr_pkg::OP_ARM, 3'd5, 16'd0, 15'd16));
      plan.push_back(item_row(ehr_pkg::OP_UPDATE, 3'd5, 16'd32767, 15'd32767));
      plan.push_back(item_row(ehr_pkg::OP_UPDATE, 3'd5, 16'd0, 15'd32767));
      plan.push_back(item_row(ehr_pkg::OP_UPDATE, 3'd5, 16'd4800, 15'd9000));
      plan.push_back(item_row(ehr_pkg::OP_UPDATE, 3'd2, 16'hFFFB, 15'd1));
      plan.push_back(item_row(ehr_pkg::OP_UPDATE, 3'd6, 16'd7, 15'd7));
      plan.push_back(item_row(ehr_pkg::OP_ARM, 3'd7, 16'h7FFF, 15'h7FFF));
      // zero shift, zero threshold, zero floor: every update reports
      plan.push_back(csr_row(ehr_pkg::CSR_EMA_SHIFT, 15'd0));
      plan.push_back(csr_row(ehr_pkg::CSR_THRESHOLD, 15'd0));
      plan.push_back(csr_row(ehr_pkg::CSR_VREF_FLOOR, 15'd0));
      plan.push_back(fixed_row(ehr_pkg::OP_UPDATE, 3'd1, 16'd300, 15'd0, '{300, 300, 1, 0}));
      plan.push_back(fixed_row(ehr_pkg::OP_UPDATE, 3'd1, 16'd300, 15'd300,
                               '{300, 300, 1, 10000}));
      // upper extremes
      plan.push_back(csr_row(ehr_pkg::CSR_EMA_SHIFT, 15'd15));
      plan.push_back(csr_row(ehr_pkg::CSR_THRESHOLD, 15'h7FFF));
      plan.push_back(csr_row(ehr_pkg::CSR_VREF_FLOOR, 15'h7FFF));
      plan.push_back(fixed_row(ehr_pkg::OP_SEED, 3'd0, 16'd0, 15'd32767, '{0, 0, 0, 0}));
      plan.push_back(fixed_row(ehr_pkg::OP_ARM, 3'd0, 16'd0, 15'd32766, '{0, 0, 0, 0}));
      plan.push_back(item_row(ehr_pkg::OP_UPDATE, 3'd0, 16'd32767, 15'd32767));
      plan.push_back(csr_row(ehr_pkg::CSR_EMA_SHIFT, 15'd0));
      plan.push_back(fixed_row(ehr_pkg::OP_UPDATE, 3'd0, 16'd32767, 15'd32767,
                               '{32767, 32767, 1, 10000}));
      plan.push_back(item_row(ehr_pkg::OP_UPDATE, 3'd0, 16'd0, 15'd32767));
      plan.push_back(csr_row(ehr_pkg::CSR_EMA_SHIFT, 15'd15));
      plan.push_back(item_row(ehr_pkg::OP_SEED, 3'd3, 16'd32767, 15'd32767));
      plan.push_back(item_row(ehr_pkg::OP_UPDATE, 3'd3, 16'd0, 15'd32767));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            drain(DRAIN_CYCLES);
            write_csr(row.idx, row.value);
         end else begin
            send_item(row.op, row.ch, row.sample, row.vref, row.kind == ROW_FIXED, row.want);
         end
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain(DRAIN_CYCLES);
         r = $urandom_range(0, 99);
         write_csr(ehr_pkg::CSR_EMA_SHIFT, (r < 15) ? 15'd0 : (r < 30) ? 15'd15
                                  : ehr_pkg::VAL_W'($urandom_range(1, 6)));
         r = $urandom_range(0, 99);
         write_csr(ehr_pkg::CSR_THRESHOLD, (r < 15) ? 15'd0 : (r < 25) ? 15'h7FFF
                                  : ehr_pkg::VAL_W'($urandom_range(1, 400)));
         r = $urandom_range(0, 99);
         write_csr(ehr_pkg::CSR_VREF_FLOOR, (r < 15) ? 15'd0 : (r < 25) ? 15'h7FFF
                                   : ehr_pkg::VAL_W'($urandom_range(1, 2000)));
         // some phases run with no idling at all on one or both sides
         sender_idles = !(phase == 0 || phase == 4);
         receiver_stalls = !(phase == 2 || phase == 4);
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            if (phase == 3 && items_sent - phase_start >= 80 && items_sent - phase_start < 100)
               drain(0);
            if ($urandom_range(0, 99) < 80) begin
               run_sequence();
            end else begin
               send_item(ehr_pkg::op_type'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         16'($urandom_range(0, 65535)), 15'($urandom_range(0, 32767)),
                         1'b0, '0);
            end
         end
      end

      drain(DRAIN_CYCLES);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
